// ===== sv/vsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, widths and the glyph stroke table of the vector character generator.
// Used by the channel interfaces and the top level; depends on nothing.

package vsc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EXT_W       = COORD_WIDTH + 2;
    localparam int OUT_W       = 16;
    localparam int CHAR_W      = 8;
    localparam int SIZE_W      = 8;
    localparam int ORG_W       = 12;
    localparam int STROKE_W    = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int SEG_CNT_W   = 3;
    localparam int GIDX_W      = 6;
    localparam int PT_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SIZE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd8;

    // x point codes
    localparam logic [PT_W-1:0] PXL  = 3'd0;
    localparam logic [PT_W-1:0] PXR  = 3'd1;
    localparam logic [PT_W-1:0] PXRQ = 3'd2;
    localparam logic [PT_W-1:0] PXM  = 3'd3;
    localparam logic [PT_W-1:0] PXRM = 3'd4;

    // y point codes
    localparam logic [PT_W-1:0] PYT  = 3'd0;
    localparam logic [PT_W-1:0] PYB  = 3'd1;
    localparam logic [PT_W-1:0] PYM  = 3'd2;
    localparam logic [PT_W-1:0] PYTQ = 3'd3;
    localparam logic [PT_W-1:0] PYBQ = 3'd4;
    localparam logic [PT_W-1:0] PYBX = 3'd5;
    localparam logic [PT_W-1:0] PYBM = 3'd6;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [PT_W-1:0] x0;
        logic [PT_W-1:0] y0;
        logic [PT_W-1:0] x1;
        logic [PT_W-1:0] y1;
    } t_seg;

    typedef struct packed {
        logic [SEG_CNT_W-1:0] count;
        t_seg [5:0]           seg;
    } t_glyph;

    typedef struct packed {
        logic              hit;
        logic [GIDX_W-1:0] idx;
    } t_gsel;

    localparam t_seg SEG_LTLB = '{PXL, PYT, PXL, PYB};
    localparam t_seg SEG_RTRB = '{PXR, PYT, PXR, PYB};
    localparam t_seg SEG_LTRT = '{PXL, PYT, PXR, PYT};
    localparam t_seg SEG_LBRB = '{PXL, PYB, PXR, PYB};
    localparam t_seg SEG_LMRM = '{PXL, PYM, PXR, PYM};
    localparam t_seg SEG_MTMB = '{PXM, PYT, PXM, PYB};

    function automatic t_seg mk_seg(input logic [PT_W-1:0] x0, input logic [PT_W-1:0] y0,
                                    input logic [PT_W-1:0] x1, input logic [PT_W-1:0] y1);
        t_seg s;
        s.x0 = x0;
        s.y0 = y0;
        s.x1 = x1;
        s.y1 = y1;
        return s;
    endfunction

    function automatic t_gsel glyph_lookup(input logic [CHAR_W-1:0] code);
        t_gsel       r;
        logic [CHAR_W-1:0] d;
        r = '0;
        d = '0;
        if (code >= 8'd65 && code <= 8'd90) begin
            d     = code - 8'd65;
            r.hit = 1'b1;
            r.idx = d[GIDX_W-1:0];
        end else if (code >= 8'd48 && code <= 8'd57) begin
            d     = code - 8'd48 + 8'd26;
            r.hit = 1'b1;
            r.idx = d[GIDX_W-1:0];
        end else if (code == 8'd44) begin
            r.hit = 1'b1;
            r.idx = 6'd36;
        end else if (code == 8'd45) begin
            r.hit = 1'b1;
            r.idx = 6'd37;
        end
        return r;
    endfunction

    function automatic t_glyph glyph_rom(input logic [GIDX_W-1:0] idx);
        t_glyph g;
        g = '0;
        unique case (idx)
            6'd0: begin // A
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LTRT;
                g.seg[3] = SEG_LMRM;
            end
            6'd1: begin // B
                g.count = 3'd5;
                g.seg[0] = SEG_LTLB;
                g.seg[1] = mk_seg(PXL, PYT, PXR, PYTQ);
                g.seg[2] = mk_seg(PXL, PYM, PXR, PYTQ);
                g.seg[3] = mk_seg(PXL, PYB, PXR, PYBQ);
                g.seg[4] = mk_seg(PXL, PYBM, PXR, PYBQ);
            end
            6'd2: begin // C
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LBRB;
            end
            6'd3: begin // D
                g.count = 3'd6;
                g.seg[0] = SEG_LTLB;
                g.seg[1] = mk_seg(PXL, PYB, PXRQ, PYB);
                g.seg[2] = mk_seg(PXL, PYT, PXRQ, PYT);
                g.seg[3] = mk_seg(PXR, PYBQ, PXR, PYTQ);
                g.seg[4] = mk_seg(PXRQ, PYT, PXR, PYTQ);
                g.seg[5] = mk_seg(PXRQ, PYB, PXR, PYBQ);
            end
            6'd4: begin // E
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
                g.seg[3] = SEG_LBRB;
            end
            6'd5: begin // F
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
            end
            6'd6: begin // G
                g.count = 3'd5;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LBRB;
                g.seg[3] = mk_seg(PXR, PYB, PXR, PYM);
                g.seg[4] = mk_seg(PXR, PYM, PXRM, PYM);
            end
            6'd7: begin // H
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LMRM;
            end
            6'd8: begin // I
                g.count = 3'd1;
                g.seg[0] = SEG_MTMB;
            end
            6'd9: begin // J
                g.count = 3'd3;
                g.seg[0] = SEG_RTRB; g.seg[1] = SEG_LBRB;
                g.seg[2] = mk_seg(PXL, PYB, PXL, PYBQ);
            end
            6'd10: begin // K
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB;
                g.seg[1] = mk_seg(PXR, PYT, PXL, PYM);
                g.seg[2] = mk_seg(PXR, PYB, PXL, PYM);
            end
            6'd11: begin // L
                g.count = 3'd2;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LBRB;
            end
            6'd12: begin // M
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB;
                g.seg[2] = mk_seg(PXL, PYT, PXM, PYM);
                g.seg[3] = mk_seg(PXR, PYT, PXM, PYM);
            end
            6'd13: begin // N
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB;
                g.seg[2] = mk_seg(PXL, PYT, PXR, PYB);
            end
            6'd14: begin // O
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LTRT;
                g.seg[3] = SEG_LBRB;
            end
            6'd15: begin // P
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
                g.seg[3] = mk_seg(PXR, PYT, PXR, PYM);
            end
            6'd16: begin // Q
                g.count = 3'd5;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LTRT;
                g.seg[3] = SEG_LBRB;
                g.seg[4] = mk_seg(PXM, PYB, PXR, PYBX);
            end
            6'd17: begin // R
                g.count = 3'd5;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
                g.seg[3] = mk_seg(PXR, PYT, PXR, PYM);
                g.seg[4] = mk_seg(PXRM, PYM, PXR, PYB);
            end
            6'd18: begin // S
                g.count = 3'd5;
                g.seg[0] = SEG_LTRT; g.seg[1] = SEG_LMRM; g.seg[2] = SEG_LBRB;
                g.seg[3] = mk_seg(PXL, PYT, PXL, PYM);
                g.seg[4] = mk_seg(PXR, PYM, PXR, PYB);
            end
            6'd19: begin // T
                g.count = 3'd2;
                g.seg[0] = SEG_LTRT; g.seg[1] = SEG_MTMB;
            end
            6'd20: begin // U
                g.count = 3'd3;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LBRB;
            end
            6'd21: begin // V
                g.count = 3'd2;
                g.seg[0] = mk_seg(PXL, PYT, PXM, PYB);
                g.seg[1] = mk_seg(PXR, PYT, PXM, PYB);
            end
            6'd22: begin // W
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB;
                g.seg[2] = mk_seg(PXL, PYB, PXM, PYM);
                g.seg[3] = mk_seg(PXR, PYB, PXM, PYM);
            end
            6'd23: begin // X
                g.count = 3'd2;
                g.seg[0] = mk_seg(PXL, PYT, PXR, PYB);
                g.seg[1] = mk_seg(PXR, PYT, PXL, PYB);
            end
            6'd24: begin // Y
                g.count = 3'd3;
                g.seg[0] = mk_seg(PXM, PYM, PXM, PYB);
                g.seg[1] = mk_seg(PXL, PYT, PXM, PYM);
                g.seg[2] = mk_seg(PXR, PYT, PXM, PYM);
            end
            6'd25: begin // Z
                g.count = 3'd3;
                g.seg[0] = SEG_LTRT; g.seg[1] = SEG_LBRB;
                g.seg[2] = mk_seg(PXR, PYT, PXL, PYB);
            end
            6'd26: begin // 0
                g.count = 3'd4;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_RTRB; g.seg[2] = SEG_LTRT;
                g.seg[3] = SEG_LBRB;
            end
            6'd27: begin // 1
                g.count = 3'd1;
                g.seg[0] = SEG_MTMB;
            end
            6'd28: begin // 2
                g.count = 3'd5;
                g.seg[0] = SEG_LTRT; g.seg[1] = SEG_LMRM; g.seg[2] = SEG_LBRB;
                g.seg[3] = mk_seg(PXR, PYT, PXR, PYM);
                g.seg[4] = mk_seg(PXL, PYM, PXL, PYB);
            end
            6'd29: begin // 3
                g.count = 3'd4;
                g.seg[0] = SEG_RTRB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
                g.seg[3] = SEG_LBRB;
            end
            6'd30: begin // 4
                g.count = 3'd3;
                g.seg[0] = SEG_RTRB; g.seg[1] = SEG_LMRM;
                g.seg[2] = mk_seg(PXL, PYT, PXL, PYM);
            end
            6'd31: begin // 5
                g.count = 3'd5;
                g.seg[0] = SEG_LTRT; g.seg[1] = SEG_LMRM; g.seg[2] = SEG_LBRB;
                g.seg[3] = mk_seg(PXL, PYT, PXL, PYM);
                g.seg[4] = mk_seg(PXR, PYM, PXR, PYB);
            end
            6'd32: begin // 6
                g.count = 3'd5;
                g.seg[0] = SEG_LTLB; g.seg[1] = SEG_LTRT; g.seg[2] = SEG_LMRM;
                g.seg[3] = SEG_LBRB;
                g.seg[4] = mk_seg(PXR, PYB, PXR, PYM);
            end
            6'd33: begin // 7
                g.count = 3'd2;
                g.seg[0] = SEG_LTRT;
                g.seg[1] = mk_seg(PXR, PYT, PXL, PYB);
            end
            6'd34: begin // 8
                g.count = 3'd5;
                g.seg[0] = SEG_RTRB; g.seg[1] = SEG_LMRM; g.seg[2] = SEG_LTLB;
                g.seg[3] = SEG_LTRT; g.seg[4] = SEG_LBRB;
            end
            6'd35: begin // 9
                g.count = 3'd5;
                g.seg[0] = SEG_RTRB; g.seg[1] = SEG_LMRM;
                g.seg[2] = mk_seg(PXL, PYT, PXL, PYM);
                g.seg[3] = SEG_LTRT; g.seg[4] = SEG_LBRB;
            end
            6'd36: begin // comma
                g.count = 3'd1;
                g.seg[0] = mk_seg(PXM, PYBQ, PXL, PYBX);
            end
            6'd37: begin // hyphen
                g.count = 3'd1;
                g.seg[0] = SEG_LMRM;
            end
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vsc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the vector character generator: one character word per handshake.
// Depends on vsc_pkg.

interface vsc_in_if;
    import vsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              start_of_text;

    modport source (output valid, output char_code, output start_of_text, input ready);
    modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

`default_nettype wire

// ===== sv/vsc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output channel of the vector character generator: one segment word per handshake.
// Depends on vsc_pkg.

interface vsc_out_if;
    import vsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_W-1:0]    seg_x0;
    logic [OUT_W-1:0]    seg_y0;
    logic [OUT_W-1:0]    seg_x1;
    logic [OUT_W-1:0]    seg_y1;
    logic [STROKE_W-1:0] stroke_width;
    logic                last_segment;

    modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                    output seg_y1, output stroke_width, output last_segment, input ready);
    modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                    input seg_y1, input stroke_width, input last_segment, output ready);
endinterface

`default_nettype wire

// ===== sv/vector_stroke_char_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the vector character generator: sequencer, segment endpoint unit, pen register.
// Depends on vsc_pkg, vsc_in_if and vsc_out_if.

// Each accepted character word is looked up in the glyph table and its segments
// come out one word per cycle while the output side keeps up, last_segment set on
// the final one. A character is accepted first; then each of its segments goes
// through the shared endpoint unit, which forms both endpoints of one segment
// from the pen position, origin_y and glyph_size. An unknown character emits
// nothing and only moves the pen. The input is not ready while a character is
// being drawn; a finished segment waits in the output register, and the next
// character is accepted while the last one is still held there. Configuration
// writes take effect at once and belong between characters.

module vector_stroke_char_generator (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [vsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [vsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    vsc_in_if.sink                            i_in,
    vsc_out_if.source                         o_out
);
    import vsc_pkg::*;

    t_state               r_state;
    t_state               n_state;

    logic [ORG_W-1:0]       r_origin_x;
    logic [ORG_W-1:0]       r_origin_y;
    logic [SIZE_W-1:0]      r_glyph_size;
    logic [COORD_WIDTH-1:0] r_pen_x;
    logic [COORD_WIDTH-1:0] r_left;
    logic [GIDX_W-1:0]      r_gidx;
    logic [SEG_CNT_W-1:0]   r_seg;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_seg_x0;
    logic [OUT_W-1:0]       r_seg_y0;
    logic [OUT_W-1:0]       r_seg_x1;
    logic [OUT_W-1:0]       r_seg_y1;
    logic [STROKE_W-1:0]    r_stroke;
    logic                   r_last;

    logic                   in_ready;
    logic                   in_accept;
    logic                   seg_load;
    logic                   seg_last;
    t_gsel                  gsel;
    t_glyph                 glyph;
    t_seg                   cur;
    logic [COORD_WIDTH-1:0] acc_left;
    logic [EXT_W-1:0]       adv_sum;
    logic [EXT_W-1:0]       left_ext;
    logic [EXT_W-1:0]       top_ext;
    logic [15:0]            stroke_prod;
    logic [STROKE_W-1:0]    stroke;

    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [EXT_W-1:0] v);
        if (v[EXT_W-1 -: 2] != 2'b00) begin
            return '1;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [EXT_W-1:0] x_point(input logic [PT_W-1:0] pc,
                                                 input logic [EXT_W-1:0] left,
                                                 input logic [SIZE_W-1:0] s);
        logic [EXT_W-1:0] sz;
        logic [EXT_W-1:0] mx;
        logic [EXT_W-1:0] right;
        logic [EXT_W-1:0] r;
        sz    = EXT_W'(s);
        mx    = EXT_W'(s >> 1);
        right = left + sz;
        unique case (pc)
            PXL:     r = left;
            PXR:     r = right;
            PXRQ:    r = right - (mx >> 1);
            PXM:     r = left + mx;
            PXRM:    r = right - mx;
            default: r = left;
        endcase
        return r;
    endfunction

    function automatic logic [EXT_W-1:0] y_point(input logic [PT_W-1:0] pc,
                                                 input logic [EXT_W-1:0] top,
                                                 input logic [SIZE_W-1:0] s);
        logic [EXT_W-1:0] my;
        logic [EXT_W-1:0] bottom;
        logic [EXT_W-1:0] r;
        my     = EXT_W'(s - (s >> 2));
        bottom = top + (my << 1);
        unique case (pc)
            PYT:     r = top;
            PYB:     r = bottom;
            PYM:     r = top + my;
            PYTQ:    r = top + (my >> 1);
            PYBQ:    r = bottom - (my >> 1);
            PYBX:    r = bottom + (my >> 1);
            PYBM:    r = bottom - my;
            default: r = top;
        endcase
        return r;
    endfunction

    assign gsel      = glyph_lookup(i_in.char_code);
    assign glyph     = glyph_rom(r_gidx);
    assign cur       = glyph.seg[r_seg];
    assign seg_last  = (r_seg == glyph.count - 3'd1);
    assign in_accept = i_in.valid && in_ready;

    assign acc_left  = i_in.start_of_text ? COORD_WIDTH'(r_origin_x) : r_pen_x;
    assign adv_sum   = EXT_W'(acc_left) + EXT_W'(r_glyph_size)
                     + EXT_W'(r_glyph_size >> 2) + EXT_W'(1);
    assign left_ext  = EXT_W'(r_left);
    assign top_ext   = EXT_W'(r_origin_y);

    // size/10 as (size * 205) >> 11, exact over 8 bits
    assign stroke_prod = 16'(r_glyph_size) * 16'd205;
    assign stroke      = stroke_prod[15:11] + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        seg_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid && gsel.hit) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_out_valid || o_out.ready) begin
                    seg_load = 1'b1;
                    if (seg_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_glyph_size <= SIZE_RESET;
            r_pen_x      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ORIGIN_X:   r_origin_x   <= i_cfg_data;
                    CFG_ORIGIN_Y:   r_origin_y   <= i_cfg_data;
                    CFG_GLYPH_SIZE: r_glyph_size <= i_cfg_data[SIZE_W-1:0];
                    default:        ;
                endcase
            end
            if (in_accept) begin
                r_pen_x <= sat_coord(adv_sum);
            end
            if (seg_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_left <= acc_left;
            r_gidx <= gsel.idx;
            r_seg  <= '0;
        end else if (seg_load) begin
            r_seg  <= r_seg + 3'd1;
        end
        if (seg_load) begin
            r_seg_x0 <= OUT_W'(sat_coord(x_point(cur.x0, left_ext, r_glyph_size)));
            r_seg_y0 <= OUT_W'(sat_coord(y_point(cur.y0, top_ext, r_glyph_size)));
            r_seg_x1 <= OUT_W'(sat_coord(x_point(cur.x1, left_ext, r_glyph_size)));
            r_seg_y1 <= OUT_W'(sat_coord(y_point(cur.y1, top_ext, r_glyph_size)));
            r_stroke <= stroke;
            r_last   <= seg_last;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.seg_x0       = r_seg_x0;
    assign o_out.seg_y0       = r_seg_y0;
    assign o_out.seg_x1       = r_seg_x1;
    assign o_out.seg_y1       = r_seg_y1;
    assign o_out.stroke_width = r_stroke;
    assign o_out.last_segment = r_last;

endmodule

`default_nettype wire
